// File: design/lbps_pkg.sv
// Package for the LED strip bit pulse sequencer: codes, types and fixed widths.
package lbps_pkg;

  // Fixed field widths
  localparam int LED_IDX_W   = 6;
  localparam int COLOUR_W    = 24;
  localparam int COUNT_W     = 16;
  localparam int LEDS_CFG_W  = 7;
  localparam int SLOTS_W     = 8;
  localparam int BIT_CNT_W   = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int LED_LIMIT   = 64;

  // Item codes on the op field
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEDS      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS     = 2'd3;

  // Frame phase, encoded as sent on the phase output
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LEAD  = 2'd1,
    PH_DATA  = 2'd2,
    PH_TRAIL = 2'd3
  } phase_t;

  // One stored colour: green 23:16, red 15:8, blue 7:0
  typedef logic [COLOUR_W-1:0] colour_t;

  // Access request to the colour store
  typedef struct packed {
    logic                 wr_en;
    logic [LED_IDX_W-1:0] wr_addr;
    colour_t              wr_data;
    logic                 rd_en;
    logic [LED_IDX_W-1:0] rd_addr;
  } store_req_t;

endpackage

// File: design/lbps_colour_store.sv
// Colour store: synchronous memory with per-entry valid bits so unwritten LEDs read as zero.
module lbps_colour_store #(
  parameter int MAX_LEDS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  lbps_pkg::store_req_t req,
  output lbps_pkg::colour_t   rd_data
);

  localparam int DEPTH = (MAX_LEDS < lbps_pkg::LED_LIMIT) ? MAX_LEDS : lbps_pkg::LED_LIMIT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  lbps_pkg::colour_t mem [0:DEPTH-1];
  logic [DEPTH-1:0]  valid;
  lbps_pkg::colour_t rd_word;
  logic              rd_ok;
  logic              wr_in_range;

  assign wr_in_range = 32'(req.wr_addr) < DEPTH;

  // Memory write port
  always_ff @(posedge clk) begin
    if (req.wr_en && wr_in_range) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
  end

  // Valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr_en && wr_in_range) begin
      valid[req.wr_addr[AW-1:0]] <= 1'b1;
    end
  end

  // Registered read port; the frame counter never addresses past the store
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_word <= mem[req.rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else if (req.rd_en) begin
      rd_ok <= valid[req.rd_addr[AW-1:0]];
    end
  end

  assign rd_data = rd_ok ? rd_word : '0;

endmodule

// File: design/led_strip_bit_pulse_sequencer_top.sv
// Top level of the LED strip bit pulse sequencer: frame control, store access, output stage.
//
// Input channel (in_valid / in_stall) carries one transaction per item: op 0 writes a
// colour for led_number, op 1 starts a frame (ignored while one runs), op 2 is a bit
// slot tick. Only ticks give a result on the output channel (out_valid / out_stall):
// high_count for the slot, the frame phase, and frame_last on the final trailing slot.
// A frame is reset_slots zero slots, then green, red, blue of each LED MSB first,
// then reset_slots trailing zero slots.
// A tick's store read and slot fields are clocked into the read stage at the accepting
// edge; the bit select then feeds the output register. Throughput is one item per cycle
// while in_stall is low; the store is read once per tick at the LED counter.
// When the receiver stalls, one result waits in the output register and one in the
// read stage; in_stall rises only when both are full. Reset clears the frame state,
// the configuration registers to their defaults and the store's valid bits, so every
// LED reads as off until written. The user must write configuration through cfg_write /
// cfg_index / cfg_data only while the block is idle; the block does not enforce this.
module led_strip_bit_pulse_sequencer_top #(
  parameter int MAX_LEDS       = 64,
  parameter int BYTES_EACH_LED = 3
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           op,
  input  logic [lbps_pkg::LED_IDX_W-1:0]       led_number,
  input  logic [7:0]                           red,
  input  logic [7:0]                           green,
  input  logic [7:0]                           blue,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [lbps_pkg::COUNT_W-1:0]         high_count,
  output logic [1:0]                           phase,
  output logic                                 frame_last,
  input  logic                                 cfg_write,
  input  logic [lbps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lbps_pkg::COUNT_W-1:0]         cfg_data
);

  localparam int LED_CAP      = (MAX_LEDS < lbps_pkg::LED_LIMIT) ? MAX_LEDS : lbps_pkg::LED_LIMIT;
  localparam int BITS_PER_LED = 8 * BYTES_EACH_LED;
  localparam int COLOUR_BITS  = 24;

  // Configuration registers
  logic [lbps_pkg::COUNT_W-1:0]    one_high_count;
  logic [lbps_pkg::COUNT_W-1:0]    zero_high_count;
  logic [lbps_pkg::LEDS_CFG_W-1:0] leds_in_use;
  logic [lbps_pkg::SLOTS_W-1:0]    reset_slots;

  // Frame state
  lbps_pkg::phase_t                frame_phase, frame_phase_next;
  logic [lbps_pkg::LED_IDX_W-1:0]  led_counter, led_counter_next;
  logic [lbps_pkg::BIT_CNT_W-1:0]  bit_counter, bit_counter_next;
  logic [lbps_pkg::SLOTS_W-1:0]    reset_counter, reset_counter_next;
  logic                            last_slot;

  // Read stage
  logic                            s1_valid;
  lbps_pkg::phase_t                s1_phase;
  logic                            s1_last;
  logic [lbps_pkg::BIT_CNT_W-1:0]  s1_bit;

  logic                            in_accept, tick, start, out_take, s1_load;
  logic [lbps_pkg::LEDS_CFG_W-1:0] led_total;
  logic [lbps_pkg::SLOTS_W-1:0]    slot_total;
  logic                            slots_done, bits_done, leds_done;
  lbps_pkg::store_req_t            store_req;
  lbps_pkg::colour_t               store_data;
  logic                            data_bit;

  // Handshake
  assign out_take  = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !out_take;
  assign in_accept = in_valid && !in_stall;
  assign tick      = in_accept && (op == lbps_pkg::OP_TICK);
  assign start     = in_accept && (op == lbps_pkg::OP_START);
  assign s1_load   = tick;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      one_high_count  <= 16'd57;
      zero_high_count <= 16'd28;
      leds_in_use     <= 7'd64;
      reset_slots     <= 8'd48;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lbps_pkg::REG_ONE_HIGH:  one_high_count  <= cfg_data;
        lbps_pkg::REG_ZERO_HIGH: zero_high_count <= cfg_data;
        lbps_pkg::REG_LEDS:      leds_in_use     <= cfg_data[lbps_pkg::LEDS_CFG_W-1:0];
        lbps_pkg::REG_SLOTS:     reset_slots     <= cfg_data[lbps_pkg::SLOTS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped frame lengths
  always_comb begin
    if (leds_in_use == '0) begin
      led_total = 7'd1;
    end else if (32'(leds_in_use) > LED_CAP) begin
      led_total = lbps_pkg::LEDS_CFG_W'(LED_CAP);
    end else begin
      led_total = leds_in_use;
    end
    slot_total = (reset_slots == '0) ? 8'd1 : reset_slots;
  end

  assign slots_done = ({1'b0, reset_counter} + 9'd1) >= {1'b0, slot_total};
  assign bits_done  = ({1'b0, bit_counter} + 6'd1) >= 6'(BITS_PER_LED);
  assign leds_done  = ({1'b0, led_counter} + 7'd1) >= led_total;

  // Next phase
  always_comb begin
    frame_phase_next = frame_phase;
    if (start && frame_phase == lbps_pkg::PH_IDLE) begin
      frame_phase_next = lbps_pkg::PH_LEAD;
    end else if (tick) begin
      unique case (frame_phase)
        lbps_pkg::PH_LEAD:  if (slots_done) frame_phase_next = lbps_pkg::PH_DATA;
        lbps_pkg::PH_DATA:  if (bits_done && leds_done) frame_phase_next = lbps_pkg::PH_TRAIL;
        lbps_pkg::PH_TRAIL: if (slots_done) frame_phase_next = lbps_pkg::PH_IDLE;
        lbps_pkg::PH_IDLE:  ;
      endcase
    end
  end

  // Counter updates and slot flags
  always_comb begin
    led_counter_next   = led_counter;
    bit_counter_next   = bit_counter;
    reset_counter_next = reset_counter;
    last_slot          = 1'b0;
    if (start && frame_phase == lbps_pkg::PH_IDLE) begin
      led_counter_next   = '0;
      bit_counter_next   = '0;
      reset_counter_next = '0;
    end else if (tick) begin
      unique case (frame_phase)
        lbps_pkg::PH_LEAD: begin
          if (slots_done) begin
            reset_counter_next = '0;
            led_counter_next   = '0;
            bit_counter_next   = '0;
          end else begin
            reset_counter_next = reset_counter + 8'd1;
          end
        end
        lbps_pkg::PH_DATA: begin
          if (bits_done) begin
            bit_counter_next = '0;
            if (leds_done) begin
              reset_counter_next = '0;
              led_counter_next   = '0;
            end else begin
              led_counter_next = led_counter + 6'd1;
            end
          end else begin
            bit_counter_next = bit_counter + 5'd1;
          end
        end
        lbps_pkg::PH_TRAIL: begin
          if (slots_done) begin
            last_slot          = 1'b1;
            reset_counter_next = '0;
          end else begin
            reset_counter_next = reset_counter + 8'd1;
          end
        end
        lbps_pkg::PH_IDLE: ;
      endcase
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase   <= lbps_pkg::PH_IDLE;
      led_counter   <= '0;
      bit_counter   <= '0;
      reset_counter <= '0;
    end else begin
      frame_phase   <= frame_phase_next;
      led_counter   <= led_counter_next;
      bit_counter   <= bit_counter_next;
      reset_counter <= reset_counter_next;
    end
  end

  // Store access: writes land at acceptance, ticks read the current LED
  always_comb begin
    store_req.wr_en   = in_accept && (op == lbps_pkg::OP_WRITE);
    store_req.wr_addr = led_number;
    store_req.wr_data = {green, red, blue};
    store_req.rd_en   = s1_load;
    store_req.rd_addr = led_counter;
  end

  lbps_colour_store #(
    .MAX_LEDS (MAX_LEDS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (store_req),
    .rd_data (store_data)
  );

  // Read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (out_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_phase <= frame_phase;
      s1_last  <= last_slot;
      s1_bit   <= bit_counter;
    end
  end

  // Bit select, MSB first; a fourth byte sends zero bits
  always_comb begin
    if (32'(s1_bit) < COLOUR_BITS) begin
      data_bit = store_data[5'(COLOUR_BITS - 1) - s1_bit];
    end else begin
      data_bit = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && s1_valid) begin
      if (s1_phase == lbps_pkg::PH_DATA) begin
        high_count <= data_bit ? one_high_count : zero_high_count;
      end else begin
        high_count <= '0;
      end
      phase      <= s1_phase;
      frame_last <= s1_last;
    end
  end

endmodule
